// ----- rtl/sbo_pkg.sv -----
// Shared types and codes for the slot buffer and its cells.
package sbo_pkg;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  localparam logic [1:0] ST_STORED    = 2'd0;
  localparam logic [1:0] ST_DISPLACED = 2'd1;
  localparam logic [1:0] ST_TAKEN     = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] request_id;
    logic [31:0] arrival_time;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] request_out;
    logic [31:0] wait_time;
    logic        has_free;
    logic        is_empty;
  } out_item_t;

  // Search packet that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic        go;
    logic        action;
    logic        free1;   // a free slot has been picked
    logic        free2;   // a second free slot was seen
    logic        found;   // a candidate is held
    logic        used2;   // a second used slot was seen
    logic [31:0] arr;
    logic [15:0] id;
  } scan_pkt_t;

  // Update broadcast to all cells when the search ends.
  typedef struct packed {
    logic        en;
    logic        action;
    logic [15:0] id;
    logic [31:0] arr;
  } commit_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

endpackage

// ----- rtl/sbo_cell.sv -----
// One slot of the buffer with its stage of the search chain.
module sbo_cell
  import sbo_pkg::*;
#(
  parameter int unsigned      IDX_W  = 3,
  parameter logic [IDX_W-1:0] MY_IDX = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_pkt_t        pkt_in,
  input  logic [IDX_W-1:0] idx_in,
  output scan_pkt_t        pkt_out,
  output logic [IDX_W-1:0] idx_out,
  input  commit_t          commit,
  input  logic [IDX_W-1:0] commit_idx
);

  logic             valid_r;
  logic [15:0]      id_r;
  logic [31:0]      arr_r;
  scan_pkt_t        pkt_r;
  scan_pkt_t        pkt_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             pick;

  always_comb begin
    pkt_nxt = pkt_in;
    pick    = 1'b0;
    if (pkt_in.action == ACT_PUT) begin
      if (!pkt_in.free1) begin
        if (!valid_r) begin
          pick          = 1'b1;
          pkt_nxt.free1 = 1'b1;
        end else if (!pkt_in.found || (arr_r > pkt_in.arr)) begin
          pick = 1'b1;
        end
      end else if (!valid_r) begin
        pkt_nxt.free2 = 1'b1;
      end
    end else if (valid_r) begin
      if (pkt_in.found) begin
        pkt_nxt.used2 = 1'b1;
      end
      if (!pkt_in.found || (arr_r < pkt_in.arr)) begin
        pick = 1'b1;
      end
    end
    idx_nxt = idx_in;
    if (pick) begin
      pkt_nxt.found = 1'b1;
      pkt_nxt.arr   = arr_r;
      pkt_nxt.id    = id_r;
      idx_nxt       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.go <= 1'b0;
    end else begin
      pkt_r.go <= pkt_nxt.go;
    end
    pkt_r.action <= pkt_nxt.action;
    pkt_r.free1  <= pkt_nxt.free1;
    pkt_r.free2  <= pkt_nxt.free2;
    pkt_r.found  <= pkt_nxt.found;
    pkt_r.used2  <= pkt_nxt.used2;
    pkt_r.arr    <= pkt_nxt.arr;
    pkt_r.id     <= pkt_nxt.id;
    idx_r        <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (commit.en && (commit_idx == MY_IDX)) begin
      valid_r <= (commit.action == ACT_PUT);
    end
  end

  always_ff @(posedge clk) begin
    if (commit.en && (commit_idx == MY_IDX) && (commit.action == ACT_PUT)) begin
      id_r  <= commit.id;
      arr_r <= commit.arr;
    end
  end

  assign pkt_out = pkt_r;
  assign idx_out = idx_r;

endmodule

// ----- rtl/slot_buffer_oldest_out_newest_drop.sv -----
// Top level of the slot buffer: a row of slot cells searched by a walking packet.
//
// Each item runs as one search from start to its result: the search packet
// passes one slot cell per cycle down the row, and the slot update and the
// result register are written from it as it comes out of the last cell.
// busy stays high while the packet is in the row and start is ignored meanwhile. The
// result is shown on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall it, so it must take every result as it comes.
module slot_buffer_oldest_out_newest_drop
  import sbo_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  fsm_state_t       state_r;
  fsm_state_t       state_nxt;
  in_item_t         item_r;
  scan_pkt_t        pkt_chain [SLOTS+1];
  logic [IDX_W-1:0] idx_chain [SLOTS+1];
  scan_pkt_t        head_pkt;
  scan_pkt_t        last_pkt;
  commit_t          commit;
  logic             accept;
  logic             scan_done;
  out_item_t        result;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign accept    = start && !busy;
  assign last_pkt  = pkt_chain[SLOTS];
  assign scan_done = last_pkt.go;

  always_comb begin
    head_pkt        = '0;
    head_pkt.go     = accept;
    head_pkt.action = in_data.action;
  end

  assign pkt_chain[0] = head_pkt;
  assign idx_chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sbo_cell #(
      .IDX_W  (IDX_W),
      .MY_IDX (IDX_W'(i))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .pkt_in     (pkt_chain[i]),
      .idx_in     (idx_chain[i]),
      .pkt_out    (pkt_chain[i+1]),
      .idx_out    (idx_chain[i+1]),
      .commit     (commit),
      .commit_idx (idx_chain[SLOTS])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (scan_done) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = 1'b0;
    commit     = '0;
    commit.action = item_r.action;
    commit.id     = item_r.request_id;
    commit.arr    = item_r.arrival_time;
    case (state_r)
      FSM_IDLE: busy = 1'b0;
      FSM_SCAN: begin
        busy      = 1'b1;
        commit.en = scan_done && ((item_r.action == ACT_PUT) || last_pkt.found);
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    result = '0;
    if (item_r.action == ACT_PUT) begin
      result.is_empty = 1'b0;
      if (last_pkt.free1) begin
        result.status   = ST_STORED;
        result.has_free = last_pkt.free2;
      end else begin
        result.status      = ST_DISPLACED;
        result.request_out = last_pkt.id;
        result.wait_time   = item_r.now_time - last_pkt.arr;
        result.has_free    = 1'b0;
      end
    end else if (last_pkt.found) begin
      result.status      = ST_TAKEN;
      result.request_out = last_pkt.id;
      result.wait_time   = item_r.now_time - last_pkt.arr;
      result.has_free    = 1'b1;
      result.is_empty    = !last_pkt.used2;
    end else begin
      result.status   = ST_EMPTY;
      result.has_free = 1'b1;
      result.is_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == FSM_SCAN) && scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (scan_done) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
